/* rtl/iitt_pkg.sv */
package iitt_pkg;

  localparam int ICON_SIZE       = 32;
  localparam int TEXTURE_SIZE    = 48;
  localparam int PALETTE_ENTRIES = 16;

  localparam int ICON_ACROSS = ICON_SIZE / 8;
  localparam int ICON_BYTES  = ICON_ACROSS * ICON_ACROSS * 32;
  localparam int TEX_ACROSS  = TEXTURE_SIZE / 8;
  localparam int TEX_TILES   = TEX_ACROSS * TEX_ACROSS;
  localparam int INSET       = (TEXTURE_SIZE - ICON_SIZE) / 2;
  localparam int TILE_TEXELS = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] FILL_RESET =
    16'((((8'h24 >> 3) << 11) | ((8'h28 >> 2) << 5) | (8'h32 >> 3)));

  typedef enum logic [1:0] {
    OP_PALETTE = 2'd0,
    OP_BITMAP  = 2'd1,
    OP_FILL    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_PALETTE = 2'd0,
    CMD_TEXELS  = 2'd1,
    CMD_FILL    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  palette_index;
    logic [14:0] color_bgr555;
    logic [8:0]  byte_offset;
    logic [7:0]  bitmap_byte;
    logic [5:0]  tile_number;
  } in_item_t;

  typedef struct packed {
    logic [11:0] texel_address;
    logic [15:0] texel_color;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  pal_index;
    logic [15:0] pal_color;
    logic [11:0] addr0;
    logic [11:0] addr1;
    logic [7:0]  pixels;
    logic [5:0]  tile;
  } cmd_t;

  function automatic logic [11:0] tex_addr(input logic [5:0] x, input logic [5:0] y);
    logic [5:0] t;
    t = 6'(y[5:3] * TEX_ACROSS) + 6'(x[5:3]);
    return {t, y[2], x[2], y[1], x[1], y[0], x[0]};
  endfunction

endpackage

/* rtl/iitt_front.sv */
module iitt_front (
  input  logic               in_valid,
  input  iitt_pkg::in_item_t in_item,
  output logic               in_stall,
  input  logic               full,
  output logic               push,
  output iitt_pkg::cmd_t     push_cmd
);

  logic [3:0] tile;
  logic [1:0] row;
  logic [1:0] col;
  logic [5:0] x0;
  logic [5:0] x1;
  logic [5:0] y;
  logic [4:0] g;
  logic       keep;

  always_comb begin
    tile = in_item.byte_offset[8:5];
    row = 2'd0;
    for (int r = 1; r < iitt_pkg::ICON_ACROSS; r++) begin
      if (tile >= 4'(r * iitt_pkg::ICON_ACROSS)) begin
        row = 2'(r);
      end
    end
    col = 2'(tile - 4'(row * iitt_pkg::ICON_ACROSS));
    x0 = 6'({col, 3'b000}) + 6'({in_item.byte_offset[1:0], 1'b0}) + 6'(iitt_pkg::INSET);
    x1 = x0 + 6'd1;
    y = 6'({row, 3'b000}) + 6'(in_item.byte_offset[4:2]) + 6'(iitt_pkg::INSET);
    g = in_item.color_bgr555[9:5];

    push_cmd.kind = iitt_pkg::CMD_PALETTE;
    push_cmd.pal_index = in_item.palette_index;
    push_cmd.pal_color = {in_item.color_bgr555[4:0], g, g[4], in_item.color_bgr555[14:10]};
    push_cmd.addr0 = iitt_pkg::tex_addr(x0, y);
    push_cmd.addr1 = iitt_pkg::tex_addr(x1, y);
    push_cmd.pixels = in_item.bitmap_byte;
    push_cmd.tile = in_item.tile_number;

    keep = 1'b0;
    case (iitt_pkg::op_t'(in_item.operation))
      iitt_pkg::OP_PALETTE: begin
        keep = 1'b1;
      end
      iitt_pkg::OP_BITMAP: begin
        push_cmd.kind = iitt_pkg::CMD_TEXELS;
        keep = 10'(in_item.byte_offset) < 10'(iitt_pkg::ICON_BYTES);
      end
      iitt_pkg::OP_FILL: begin
        push_cmd.kind = iitt_pkg::CMD_FILL;
        keep = 7'(in_item.tile_number) < 7'(iitt_pkg::TEX_TILES);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = full;
  assign push = in_valid && !full && keep;

endmodule

/* rtl/iitt_queue.sv */
module iitt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  iitt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output iitt_pkg::cmd_t head_cmd
);

  iitt_pkg::cmd_t entries [iitt_pkg::QUEUE_DEPTH];
  logic [iitt_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [iitt_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [iitt_pkg::QUEUE_AW:0]   count;

  assign full = count == (iitt_pkg::QUEUE_AW+1)'(iitt_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/iitt_back.sv */
module iitt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         fill_color,
  input  logic                head_valid,
  input  iitt_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output iitt_pkg::out_item_t out_item
);

  localparam logic [5:0] FILL_LAST = 6'(iitt_pkg::TILE_TEXELS - 1);

  logic [15:0] palette [iitt_pkg::PALETTE_ENTRIES];
  logic [5:0]  cnt;
  logic [5:0]  cnt_next;
  logic        load_ok;
  logic        emit;
  logic        pal_we;
  logic [3:0]  nibble;
  iitt_pkg::out_item_t emit_item;

  assign load_ok = !out_valid || !out_stall;

  always_comb begin
    pop = 1'b0;
    emit = 1'b0;
    pal_we = 1'b0;
    cnt_next = cnt;
    nibble = cnt[0] ? head_cmd.pixels[7:4] : head_cmd.pixels[3:0];
    emit_item.texel_address = cnt[0] ? head_cmd.addr1 : head_cmd.addr0;
    emit_item.texel_color = (nibble == 4'd0) ? fill_color : palette[nibble];
    emit_item.last_of_run = cnt[0];
    if (head_valid) begin
      case (head_cmd.kind)
        iitt_pkg::CMD_PALETTE: begin
          pal_we = 1'b1;
          pop = 1'b1;
        end
        iitt_pkg::CMD_TEXELS: begin
          if (load_ok) begin
            emit = 1'b1;
            if (cnt[0]) begin
              pop = 1'b1;
              cnt_next = '0;
            end else begin
              cnt_next = 6'd1;
            end
          end
        end
        iitt_pkg::CMD_FILL: begin
          emit_item.texel_address = {head_cmd.tile, cnt};
          emit_item.texel_color = fill_color;
          emit_item.last_of_run = cnt == FILL_LAST;
          if (load_ok) begin
            emit = 1'b1;
            if (cnt == FILL_LAST) begin
              pop = 1'b1;
              cnt_next = '0;
            end else begin
              cnt_next = cnt + 6'd1;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (load_ok) begin
        out_valid <= emit;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
    if (pal_we) begin
      palette[head_cmd.pal_index] <= head_cmd.pal_color;
    end
  end

endmodule

/* rtl/indexed_icon_to_tiled_texture.sv */
// Converts palette-indexed icon data into RGB565 texels of a tiled, Morton-ordered
// texture. Palette loads give no output; a bitmap byte gives two texels, and a
// fill gives 64 texels, one texel per cycle while the output is not stalled,
// limited by the single output register. Accepted items wait in a four-entry
// command queue, so input transfers continue while results are still being sent.
// Palette entries must be loaded before a bitmap byte refers to them.
module indexed_icon_to_tiled_texture (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  iitt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output iitt_pkg::out_item_t out_item
);

  logic [15:0]    fill_color;
  logic           full;
  logic           push;
  logic           pop;
  logic           head_valid;
  iitt_pkg::cmd_t push_cmd;
  iitt_pkg::cmd_t head_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= iitt_pkg::FILL_RESET;
    end else if (cfg_we) begin
      fill_color <= cfg_data;
    end
  end

  iitt_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  iitt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  iitt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fill_color (fill_color),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
